>>> rtl/core/assert_macros.svh
// Assertion macros shared by the stencil RTL.
// Needs nothing else; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies property in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Condition in this cycle implies property in the next cycle.
`define ASSERT_NEXT(name, clk, rst, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/wes_pkg.sv
// Package for the 2D wave-equation stencil: beat payload types, codes and
// sequencer control types. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package wes_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_FIELD = 2'd0,
    OP_WRITE_CELL  = 2'd1,
    OP_COMPUTE     = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_FRAMES = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_SCALE  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         t_pos;
    logic [5:0]         x_pos;
    logic [5:0]         y_pos;
    logic signed [31:0] field_value;
    logic signed [31:0] velocity_value;
    logic signed [31:0] efficiency_value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] next_value;
    logic               saturated;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STORE,
    ST_CALC
  } fsm_state_t;

  typedef enum logic [4:0] {
    S_ISSUE,
    S_DOUBLE,
    S_NEGATE,
    S_TWICE,
    S_ADD_XM,
    S_ADD_XP,
    S_ADD_YM,
    S_ADD_YP,
    S_MUL_K,
    S_SAT_K,
    S_MUL_LK,
    S_SAT_LK,
    S_SUB_PREV,
    S_ADD_LK,
    S_MUL_EFF,
    S_SAT_EFF,
    S_FINISH
  } calc_step_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_MSAT
  } alu_op_t;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_RD,
    SRC_ACC,
    SRC_D,
    SRC_HOLD,
    SRC_SCALE,
    SRC_VEL,
    SRC_EFF
  } operand_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_CENTRE,
    RD_XM,
    RD_XP,
    RD_YM,
    RD_YP,
    RD_PREV
  } read_sel_t;

  typedef struct packed {
    alu_op_t op;
    logic    clear;
  } alu_ctrl_t;

  typedef struct packed {
    alu_op_t   op;
    operand_t  a_src;
    operand_t  b_src;
    read_sel_t rd;
    logic      save_d;
    logic      save_hold;
    logic      clear;
  } calc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/wes_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; used for the field store and the cell table.
`timescale 1ns / 1ps
`default_nettype none

module wes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wes_posmod.sv
// Position reduction: t, x and y taken modulo the ring and grid sizes by a
// bit-serial restoring remainder, three lanes sharing one step counter.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wes_posmod (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] t_in,
  input  logic [5:0] x_in,
  input  logic [5:0] y_in,
  input  logic [2:0] nt,
  input  logic [6:0] nx,
  input  logic [6:0] ny,
  output logic       done,
  output logic [2:0] t_mod,
  output logic [6:0] x_mod,
  output logic [6:0] y_mod
);

  localparam int STEPS = 8;
  localparam int CW = $clog2(STEPS);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [7:0]    num_t, num_x, num_y;
  logic [7:0]    rem_t, rem_x, rem_y;

  // One restoring step: bring in the next numerator bit, subtract if it fits.
  // The remainder stays below the divisor, so its top bit is always clear.
  function automatic logic [7:0] rem_step(input logic [7:0] r, input logic b,
                                          input logic [6:0] d);
    logic [7:0] s;
    s = {r[6:0], b};
    if (s >= {1'b0, d}) begin
      s = s - {1'b0, d};
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_t <= t_in;
      num_x <= {2'b00, x_in};
      num_y <= {2'b00, y_in};
      rem_t <= '0;
      rem_x <= '0;
      rem_y <= '0;
    end else if (busy) begin
      num_t <= num_t << 1;
      num_x <= num_x << 1;
      num_y <= num_y << 1;
      rem_t <= rem_step(rem_t, num_t[7], {4'b0000, nt});
      rem_x <= rem_step(rem_x, num_x[7], nx);
      rem_y <= rem_step(rem_y, num_y[7], ny);
    end
  end

  assign t_mod = rem_t[2:0];
  assign x_mod = rem_x[6:0];
  assign y_mod = rem_y[6:0];

  `ASSERT_IMPLIES(a_rem_t_below, clk, rst, done, rem_t < 8'(nt), "t remainder not reduced")
  `ASSERT_IMPLIES(a_rem_x_below, clk, rst, done, rem_x < 8'(nx), "x remainder not reduced")
  `ASSERT_IMPLIES(a_rem_y_below, clk, rst, done, rem_y < 8'(ny), "y remainder not reduced")

endmodule

`default_nettype wire

>>> rtl/core/wes_alu.sv
// Shared arithmetic unit: saturating add and subtract, a 32x32 multiply into
// a product register, and the Q16.16 floor shift with saturation.
// Depends on wes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wes_alu #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  wes_pkg::alu_ctrl_t  ctrl,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output logic signed [31:0]  acc,
  output logic                clip
);

  import wes_pkg::*;

  localparam int EFF_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int WIDE = 49;
  localparam logic signed [WIDE-1:0] SAT_HI =
    WIDE'((longint'(1) <<< (EFF_BITS - 1)) - 1);
  localparam logic signed [WIDE-1:0] SAT_LO = -SAT_HI - WIDE'(1);

  logic signed [63:0]     prod;
  logic signed [WIDE-1:0] wide;
  logic                   over, under, writes_acc;
  logic signed [31:0]     sat_res;

  always_comb begin
    wide       = '0;
    writes_acc = 1'b0;
    unique case (ctrl.op)
      ALU_ADD: begin
        wide       = {{(WIDE-32){a[31]}}, a} + {{(WIDE-32){b[31]}}, b};
        writes_acc = 1'b1;
      end
      ALU_SUB: begin
        wide       = {{(WIDE-32){a[31]}}, a} - {{(WIDE-32){b[31]}}, b};
        writes_acc = 1'b1;
      end
      ALU_MSAT: begin
        // Arithmetic shift by 16 is the floor of the product over 65536.
        wide       = {prod[63], prod[63:16]};
        writes_acc = 1'b1;
      end
      ALU_NOP, ALU_MUL: begin
        wide       = '0;
        writes_acc = 1'b0;
      end
      default: begin
        wide       = '0;
        writes_acc = 1'b0;
      end
    endcase
    over    = wide > SAT_HI;
    under   = wide < SAT_LO;
    sat_res = over ? SAT_HI[31:0] : (under ? SAT_LO[31:0] : wide[31:0]);
  end

  always_ff @(posedge clk) begin
    if (writes_acc) begin
      acc <= sat_res;
    end
    if (ctrl.op == ALU_MUL) begin
      prod <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= 1'b0;
    end else if (ctrl.clear) begin
      clip <= 1'b0;
    end else if (writes_acc && (over || under)) begin
      clip <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wave_equation_stencil_2d.sv
// Top level of the 2D wave-equation five-point stencil with a ring of frames.
// Depends on wes_pkg, wes_ram, wes_posmod, wes_alu and assert_macros.svh.
//
//   channel  | direction | handshake                   | beat
//   ---------+-----------+-----------------------------+---------------------
//   item     | in        | item_valid / item_stall     | wes_pkg::item_t
//   result   | out       | result_valid / result_stall | wes_pkg::result_t
//   cfg      | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A beat keeps the input stalled from its acceptance until the sequencer is
// idle again. Every beat first passes the bit-serial position reduction (eight
// remainder steps and a hand-over); a write beat then takes the store state,
// an ignored opcode returns straight to idle, and a compute beat runs the
// seventeen compute steps one after another, as set by the single shared
// arithmetic unit and the single field RAM port, and loads its result at the last.
// Reset (rst, synchronous) clears the sequencer and the result valid flag and
// restores the configuration defaults; the stores keep whatever they hold.
// While rst is high the block takes neither items nor register writes.
// A stalled result holds its register; the block may take the next item
// meanwhile, and only a second compute waits at its last step for the slot.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wave_equation_stencil_2d #(
  parameter int MAX_FRAMES = 4,
  parameter int GRID_X     = 64,
  parameter int GRID_Y     = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  wes_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output wes_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  import wes_pkg::*;

  localparam int CELLS       = GRID_X * GRID_Y;
  localparam int FRAME_DEPTH = MAX_FRAMES * CELLS;
  localparam int FAW         = $clog2(FRAME_DEPTH);
  localparam int CAW         = $clog2(CELLS);

  // Configuration registers, written only while the sequencer is idle.
  logic [2:0]         frames_in_use;
  logic [6:0]         width_in_use;
  logic [6:0]         height_in_use;
  logic signed [31:0] time_step_scale;

  // Sizes clamped to their legal ranges; every wrap below uses these.
  logic [2:0] nt;
  logic [6:0] nx, ny;

  fsm_state_t state, state_next;
  calc_step_t step, step_next;
  calc_ctrl_t ctrl;
  alu_ctrl_t  alu_ctrl;
  read_sel_t  rd_sel;

  item_t item_q;
  logic  item_acc, load_result;

  logic in_calc, at_finish, slot_held;

  logic       pm_done;
  logic [2:0] t_mod, tp;
  logic [6:0] x_mod, y_mod, xm, xp, ym, yp;

  logic           fld_we, fld_re, cell_we, cell_re;
  logic [FAW-1:0] fld_addr;
  logic [CAW-1:0] cell_addr;
  logic [31:0]    fld_rdata;
  logic [63:0]    cell_rdata;

  logic signed [31:0] alu_a, alu_b, acc;
  logic               clip;
  logic signed [31:0] d_hold, hold;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign cfg_ready = !rst && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use   <= 3'd2;
      width_in_use    <= 7'd64;
      height_in_use   <= 7'd64;
      time_step_scale <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAMES: frames_in_use   <= cfg_data[2:0];
        CFG_WIDTH:  width_in_use    <= cfg_data[6:0];
        CFG_HEIGHT: height_in_use   <= cfg_data[6:0];
        CFG_SCALE:  time_step_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frames_in_use == '0) begin
      nt = 3'd1;
    end else if (int'(frames_in_use) > MAX_FRAMES) begin
      nt = 3'(MAX_FRAMES);
    end else begin
      nt = frames_in_use;
    end
    if (width_in_use == '0) begin
      nx = 7'd1;
    end else if (int'(width_in_use) > GRID_X) begin
      nx = 7'(GRID_X);
    end else begin
      nx = width_in_use;
    end
    if (height_in_use == '0) begin
      ny = 7'd1;
    end else if (int'(height_in_use) > GRID_Y) begin
      ny = 7'(GRID_Y);
    end else begin
      ny = height_in_use;
    end
  end

  // ------------------------------------------------------------------
  // Input side: one item at a time, held for the whole of its work.
  // ------------------------------------------------------------------
  assign item_stall = rst || (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (item_acc) begin
      item_q <= item;
    end
  end

  wes_posmod u_posmod (
    .clk   (clk),
    .rst   (rst),
    .start (item_acc),
    .t_in  (item.t_pos),
    .x_in  (item.x_pos),
    .y_in  (item.y_pos),
    .nt    (nt),
    .nx    (nx),
    .ny    (ny),
    .done  (pm_done),
    .t_mod (t_mod),
    .x_mod (x_mod),
    .y_mod (y_mod)
  );

  // Periodic neighbours. Since each reduced position is already below its
  // size, wrapping needs only a compare against zero or the size. On an axis
  // of size one both neighbours come out as the cell itself.
  always_comb begin
    xm = (x_mod == '0) ? nx - 7'd1 : x_mod - 7'd1;
    xp = (x_mod + 7'd1 == nx) ? 7'd0 : x_mod + 7'd1;
    ym = (y_mod == '0) ? ny - 7'd1 : y_mod - 7'd1;
    yp = (y_mod + 7'd1 == ny) ? 7'd0 : y_mod + 7'd1;
    tp = (t_mod == '0) ? nt - 3'd1 : t_mod - 3'd1;
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= S_ISSUE;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (pm_done) begin
          step_next = S_ISSUE;
          if (item_q.opcode == OP_COMPUTE) begin
            state_next = ST_CALC;
          end else if (item_q.opcode == OP_WRITE_FIELD ||
                       item_q.opcode == OP_WRITE_CELL) begin
            state_next = ST_STORE;
          end else begin
            // The unused opcode leaves no trace.
            state_next = ST_IDLE;
          end
        end
      end
      ST_STORE: begin
        state_next = ST_IDLE;
      end
      ST_CALC: begin
        if (step == S_FINISH) begin
          // Wait here only while an earlier result still sits unaccepted.
          if (!result_valid || !result_stall) begin
            load_result = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          step_next = calc_step_t'(step + 1'b1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Step decoder. Each step issues at most one field read, whose data is
  // ready in the following step, and one operation of the shared unit.
  // The order of additions follows the saturating reference sequence:
  // D = 2u, L = -2D, then the x-1, x+1, y-1, y+1 neighbours, k = scale*vel,
  // L*k, D - previous frame, plus L*k, and finally the efficiency product.
  // -2D is formed as the negation of D doubled, which saturates identically.
  always_comb begin
    ctrl.op        = ALU_NOP;
    ctrl.a_src     = SRC_ZERO;
    ctrl.b_src     = SRC_ZERO;
    ctrl.rd        = RD_NONE;
    ctrl.save_d    = 1'b0;
    ctrl.save_hold = 1'b0;
    ctrl.clear     = 1'b0;
    unique case (step)
      S_ISSUE: begin
        ctrl.rd    = RD_CENTRE;
        ctrl.clear = 1'b1;
      end
      S_DOUBLE: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_RD; ctrl.b_src = SRC_RD;
      end
      S_NEGATE: begin
        ctrl.op = ALU_SUB; ctrl.a_src = SRC_ZERO; ctrl.b_src = SRC_ACC;
        ctrl.save_d = 1'b1;
      end
      S_TWICE: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_ACC;
        ctrl.rd = RD_XM;
      end
      S_ADD_XM: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_RD;
        ctrl.rd = RD_XP;
      end
      S_ADD_XP: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_RD;
        ctrl.rd = RD_YM;
      end
      S_ADD_YM: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_RD;
        ctrl.rd = RD_YP;
      end
      S_ADD_YP: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_RD;
      end
      S_MUL_K: begin
        ctrl.op = ALU_MUL; ctrl.a_src = SRC_SCALE; ctrl.b_src = SRC_VEL;
        ctrl.save_hold = 1'b1;
      end
      S_SAT_K: begin
        ctrl.op = ALU_MSAT;
      end
      S_MUL_LK: begin
        ctrl.op = ALU_MUL; ctrl.a_src = SRC_HOLD; ctrl.b_src = SRC_ACC;
      end
      S_SAT_LK: begin
        ctrl.op = ALU_MSAT;
        ctrl.rd = RD_PREV;
      end
      S_SUB_PREV: begin
        ctrl.op = ALU_SUB; ctrl.a_src = SRC_D; ctrl.b_src = SRC_RD;
        ctrl.save_hold = 1'b1;
      end
      S_ADD_LK: begin
        ctrl.op = ALU_ADD; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_HOLD;
      end
      S_MUL_EFF: begin
        ctrl.op = ALU_MUL; ctrl.a_src = SRC_ACC; ctrl.b_src = SRC_EFF;
      end
      S_SAT_EFF: begin
        ctrl.op = ALU_MSAT;
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Stores
  // ------------------------------------------------------------------
  function automatic logic [FAW-1:0] field_addr(input logic [2:0] ta,
                                                input logic [6:0] xa,
                                                input logic [6:0] ya);
    return FAW'(int'(ta) * CELLS + int'(xa) * GRID_Y + int'(ya));
  endfunction

  always_comb begin
    fld_we  = (state == ST_STORE) && (item_q.opcode == OP_WRITE_FIELD);
    cell_we = (state == ST_STORE) && (item_q.opcode == OP_WRITE_CELL);
    fld_re  = (state == ST_CALC) && (ctrl.rd != RD_NONE);
    cell_re = (state == ST_CALC) && (step == S_ISSUE);
    rd_sel  = (state == ST_CALC) ? ctrl.rd : RD_CENTRE;
    unique case (rd_sel)
      RD_XM:   fld_addr = field_addr(t_mod, xm, y_mod);
      RD_XP:   fld_addr = field_addr(t_mod, xp, y_mod);
      RD_YM:   fld_addr = field_addr(t_mod, x_mod, ym);
      RD_YP:   fld_addr = field_addr(t_mod, x_mod, yp);
      RD_PREV: fld_addr = field_addr(tp, x_mod, y_mod);
      default: fld_addr = field_addr(t_mod, x_mod, y_mod);
    endcase
    cell_addr = CAW'(int'(x_mod) * GRID_Y + int'(y_mod));
  end

  wes_ram #(
    .WIDTH (32),
    .DEPTH (FRAME_DEPTH)
  ) u_field_ram (
    .clk   (clk),
    .we    (fld_we),
    .re    (fld_re),
    .addr  (fld_addr),
    .wdata (item_q.field_value),
    .rdata (fld_rdata)
  );

  // Velocity in the upper half, efficiency in the lower half of each word.
  wes_ram #(
    .WIDTH (64),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .re    (cell_re),
    .addr  (cell_addr),
    .wdata ({item_q.velocity_value, item_q.efficiency_value}),
    .rdata (cell_rdata)
  );

  // ------------------------------------------------------------------
  // Shared arithmetic unit and its operand selection
  // ------------------------------------------------------------------
  function automatic logic signed [31:0] pick(input operand_t src,
                                              input logic [31:0] rd,
                                              input logic signed [31:0] ac,
                                              input logic signed [31:0] dv,
                                              input logic signed [31:0] hv,
                                              input logic signed [31:0] sc,
                                              input logic [63:0] cr);
    logic signed [31:0] v;
    case (src)
      SRC_RD:    v = rd;
      SRC_ACC:   v = ac;
      SRC_D:     v = dv;
      SRC_HOLD:  v = hv;
      SRC_SCALE: v = sc;
      SRC_VEL:   v = cr[63:32];
      SRC_EFF:   v = cr[31:0];
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign alu_a = pick(ctrl.a_src, fld_rdata, acc, d_hold, hold, time_step_scale,
                      cell_rdata);
  assign alu_b = pick(ctrl.b_src, fld_rdata, acc, d_hold, hold, time_step_scale,
                      cell_rdata);

  assign alu_ctrl.op    = (state == ST_CALC) ? ctrl.op : ALU_NOP;
  assign alu_ctrl.clear = (state == ST_CALC) && ctrl.clear;

  wes_alu #(
    .VALUE_BITS (VALUE_BITS)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctrl (alu_ctrl),
    .a    (alu_a),
    .b    (alu_b),
    .acc  (acc),
    .clip (clip)
  );

  // D is kept for the difference with the previous frame; hold carries L
  // into the L*k product and then L*k into the final sum.
  always_ff @(posedge clk) begin
    if (state == ST_CALC && ctrl.save_d) begin
      d_hold <= acc;
    end
    if (state == ST_CALC && ctrl.save_hold) begin
      hold <= acc;
    end
  end

  // ------------------------------------------------------------------
  // Result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.next_value <= acc;
      result.saturated  <= clip;
    end
  end

  // Shorthands for the checks below.
  assign in_calc   = (state == ST_CALC);
  assign at_finish = in_calc && (step == S_FINISH);
  assign slot_held = result_valid && result_stall;

  `ASSERT_NEXT(a_finish_loads, clk, rst, at_finish && !slot_held, result_valid, "no result")
  `ASSERT_NEXT(a_finish_waits, clk, rst, at_finish && slot_held, at_finish, "result overrun")
  `ASSERT_IMPLIES(a_calc_no_write, clk, rst, in_calc, !fld_we && !cell_we, "store write")

endmodule

`default_nettype wire
